>>> rtl/pwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared widths, the constant breakpoint table and the sideband type for the
// piecewise-linear temperature lookup.
// ----------------------------------------------------------------------------
package pwl_pkg;

  // Field widths
  localparam int CODE_W   = 12;  // converter code
  localparam int SCALED_W = 16;  // code times ten, up to 40950
  localparam int TEMP_W   = 12;  // tenths of a degree, signed

  // Breakpoint table, ordered by falling scaled code
  localparam int BP_COUNT = 30;
  localparam int BP_IDX_W = $clog2(BP_COUNT);

  // Interpolation widths: largest segment span is 570 codes and the largest
  // temperature step is 100 tenths, so the quotient fits in 7 bits.
  localparam int SPAN_W = 10;
  localparam int QUO_W  = 7;
  localparam int REM_W  = SPAN_W + QUO_W;

  localparam logic signed [TEMP_W-1:0] BP_TEMP [BP_COUNT] = '{
    -12'sd400, -12'sd350, -12'sd300, -12'sd250, -12'sd200, -12'sd150,
    -12'sd100, -12'sd50,  12'sd0,    12'sd50,   12'sd100,  12'sd150,
    12'sd200,  12'sd250,  12'sd300,  12'sd350,  12'sd400,  12'sd450,
    12'sd500,  12'sd550,  12'sd600,  12'sd650,  12'sd700,  12'sd750,
    12'sd800,  12'sd850,  12'sd900,  12'sd950,  12'sd1000, 12'sd1100
  };

  localparam logic [SCALED_W-1:0] BP_CODE [BP_COUNT] = '{
    16'd12410, 16'd12380, 16'd12340, 16'd12280, 16'd12210, 16'd12110,
    16'd11990, 16'd11850, 16'd11660, 16'd11450, 16'd11180, 16'd10880,
    16'd10530, 16'd10130, 16'd9690,  16'd9200,  16'd8680,  16'd8140,
    16'd7580,  16'd7010,  16'd6440,  16'd5890,  16'd5350,  16'd4840,
    16'd4370,  16'd3930,  16'd3520,  16'd3150,  16'd2810,  16'd2480
  };

  // Values that ride along the divider stages
  typedef struct packed {
    logic signed [TEMP_W-1:0] x0;
    logic                     in_range;
  } pwl_side_t;

endpackage

>>> rtl/pwl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Each stage holds while it is full and the one after it cannot take its beat.
// ----------------------------------------------------------------------------
module pwl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pwl_pkg::REM_W-1:0]   num_i,
  input  logic [pwl_pkg::SPAN_W-1:0]  den_i,
  input  pwl_pkg::pwl_side_t          side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pwl_pkg::QUO_W-1:0]   quo_o,
  output logic [pwl_pkg::REM_W-1:0]   rem_o,
  output pwl_pkg::pwl_side_t          side_o
);

  localparam int NS = pwl_pkg::QUO_W;

  logic                        v_q    [NS];
  logic                        en     [NS];
  logic [pwl_pkg::REM_W-1:0]   rem_q  [NS];
  logic [pwl_pkg::REM_W-1:0]   rem_d  [NS];
  logic [pwl_pkg::QUO_W-1:0]   quo_q  [NS];
  logic [pwl_pkg::QUO_W-1:0]   quo_d  [NS];
  logic [pwl_pkg::SPAN_W-1:0]  den_q  [NS];
  pwl_pkg::pwl_side_t          side_q [NS];

  genvar j;
  generate
    for (j = 0; j < NS; j++) begin : g_stage
      localparam int BIT = NS - 1 - j;

      logic                        v_in;
      logic [pwl_pkg::REM_W-1:0]   rem_in;
      logic [pwl_pkg::QUO_W-1:0]   quo_in;
      logic [pwl_pkg::SPAN_W-1:0]  den_in;
      pwl_pkg::pwl_side_t          side_in;
      logic [pwl_pkg::REM_W-1:0]   trial;

      if (j == 0) begin : g_first
        assign v_in    = in_valid_i;
        assign rem_in  = num_i;
        assign quo_in  = '0;
        assign den_in  = den_i;
        assign side_in = side_i;
      end else begin : g_next
        assign v_in    = v_q[j-1];
        assign rem_in  = rem_q[j-1];
        assign quo_in  = quo_q[j-1];
        assign den_in  = den_q[j-1];
        assign side_in = side_q[j-1];
      end

      // stage holds while full and the next stage cannot take its beat
      if (j == NS - 1) begin : g_last_en
        assign en[j] = !v_q[j] || out_ready_i;
      end else begin : g_mid_en
        assign en[j] = !v_q[j] || en[j+1];
      end

      // try to subtract the shifted divisor for this quotient bit
      assign trial = pwl_pkg::REM_W'(den_in) << BIT;

      always_comb begin
        rem_d[j] = rem_in;
        quo_d[j] = quo_in;
        if (rem_in >= trial) begin
          rem_d[j]      = rem_in - trial;
          quo_d[j][BIT] = 1'b1;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[j] <= 1'b0;
        end else if (en[j]) begin
          v_q[j] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[j] && v_in) begin
          rem_q[j]  <= rem_d[j];
          quo_q[j]  <= quo_d[j];
          den_q[j]  <= den_in;
          side_q[j] <= side_in;
        end
      end
    end
  endgenerate

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign quo_o       = quo_q[NS-1];
  assign rem_o       = rem_q[NS-1];
  assign side_o      = side_q[NS-1];

endmodule

>>> rtl/piecewise_linear_temperature_lookup.sv
`timescale 1ns / 1ps
// Takes one converter code per cycle while nothing stalls and returns one
// temperature beat per code, in order. Each code passes through 4 front
// stages, one divider stage per quotient bit, and the output register. The
// sustained rate of one beat per cycle is set by the pipelined divider,
// which retires one quotient bit per stage. Every stage holds its beat while
// it is full and the stage after it cannot take it, so a stalled output fills
// the pipeline before the input ready drops.
// ----------------------------------------------------------------------------
// piecewise_linear_temperature_lookup
// Scales the code by ten, finds the first bracketing breakpoint segment and
// interpolates the temperature in tenths of a degree, truncated toward zero.
// ----------------------------------------------------------------------------
module piecewise_linear_temperature_lookup #(
  parameter int TABLE_POINTS = 30
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pwl_pkg::CODE_W-1:0]         adc_code_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pwl_pkg::TEMP_W-1:0]  temperature_tenths_o,
  output logic                               in_range_o
);

  localparam int POINTS = (TABLE_POINTS > pwl_pkg::BP_COUNT) ? pwl_pkg::BP_COUNT
                                                              : TABLE_POINTS;

  // Stage 1: scaled code
  logic                          s1_v_q, s1_en;
  logic [pwl_pkg::SCALED_W-1:0]  s1_a_q, s1_a_d;

  // Stage 2: segment index
  logic                          s2_v_q, s2_en;
  logic [pwl_pkg::SCALED_W-1:0]  s2_a_q;
  logic [pwl_pkg::BP_IDX_W-1:0]  s2_idx_q, s2_idx_d;
  logic                          s2_hit_q, s2_hit_d;

  // Stage 3: segment constants
  logic                          s3_v_q, s3_en;
  logic signed [pwl_pkg::TEMP_W-1:0] s3_x0_q;
  logic [pwl_pkg::QUO_W-1:0]     s3_dx_q, s3_dx_d;
  logic [pwl_pkg::SPAN_W-1:0]    s3_span_q, s3_span_d;
  logic [pwl_pkg::SPAN_W-1:0]    s3_dist_q, s3_dist_d;
  logic                          s3_hit_q;
  logic [pwl_pkg::BP_IDX_W-1:0]  s2_idx_nxt;

  // Stage 4: numerator
  logic                          s4_v_q, s4_en;
  logic [pwl_pkg::REM_W-1:0]     s4_num_q;
  logic [pwl_pkg::SPAN_W-1:0]    s4_span_q;
  pwl_pkg::pwl_side_t            s4_side_q;

  // Divider and output
  logic                          div_in_ready, div_out_valid;
  logic [pwl_pkg::QUO_W-1:0]     div_quo;
  logic [pwl_pkg::REM_W-1:0]     div_rem;
  pwl_pkg::pwl_side_t            div_side;
  logic                          out_en;
  logic signed [pwl_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic                          range_q;

  // Stall chain: a stage moves when empty or when its successor moves
  assign out_en     = !out_valid_o || out_ready_i;
  assign s4_en      = !s4_v_q || div_in_ready;
  assign s3_en      = !s3_v_q || s4_en;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;

  // code * 10 = code * 8 + code * 2
  assign s1_a_d = (pwl_pkg::SCALED_W'(adc_code_i) << 3) + (pwl_pkg::SCALED_W'(adc_code_i) << 1);

  // First segment in table order with y[i+1] <= a <= y[i]
  always_comb begin
    s2_idx_d = '0;
    s2_hit_d = 1'b0;
    for (int i = POINTS - 2; i >= 0; i--) begin
      if (s1_a_q <= pwl_pkg::BP_CODE[i] && s1_a_q >= pwl_pkg::BP_CODE[i+1]) begin
        s2_idx_d = pwl_pkg::BP_IDX_W'(i);
        s2_hit_d = 1'b1;
      end
    end
  end

  // Segment constants: temperature step, code span, distance from the upper end
  assign s2_idx_nxt = s2_idx_q + pwl_pkg::BP_IDX_W'(1);
  assign s3_dx_d    = pwl_pkg::QUO_W'(pwl_pkg::BP_TEMP[s2_idx_nxt] - pwl_pkg::BP_TEMP[s2_idx_q]);
  assign s3_span_d  = pwl_pkg::SPAN_W'(pwl_pkg::BP_CODE[s2_idx_q] - pwl_pkg::BP_CODE[s2_idx_nxt]);
  assign s3_dist_d  = pwl_pkg::SPAN_W'(pwl_pkg::BP_CODE[s2_idx_q] - s2_a_q);

  // Final add; negative results round up so the sum truncates toward zero
  always_comb begin
    temp_d = div_side.x0 + $signed(pwl_pkg::TEMP_W'(div_quo));
    if (div_side.x0 < 0 && div_rem != '0) begin
      temp_d = temp_d + pwl_pkg::TEMP_W'(1);
    end
    if (!div_side.in_range) begin
      temp_d = '0;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_en)  s1_v_q      <= in_valid_i;
      if (s2_en)  s2_v_q      <= s1_v_q;
      if (s3_en)  s3_v_q      <= s2_v_q;
      if (s4_en)  s4_v_q      <= s3_v_q;
      if (out_en) out_valid_o <= div_out_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_a_q <= s1_a_d;
    end
    if (s2_en && s1_v_q) begin
      s2_a_q   <= s1_a_q;
      s2_idx_q <= s2_idx_d;
      s2_hit_q <= s2_hit_d;
    end
    if (s3_en && s2_v_q) begin
      s3_x0_q   <= pwl_pkg::BP_TEMP[s2_idx_q];
      s3_dx_q   <= s3_dx_d;
      s3_span_q <= s3_span_d;
      s3_dist_q <= s3_dist_d;
      s3_hit_q  <= s2_hit_q;
    end
    if (s4_en && s3_v_q) begin
      s4_num_q           <= pwl_pkg::REM_W'(s3_dx_q * s3_dist_q);
      s4_span_q          <= s3_span_q;
      s4_side_q.x0       <= s3_x0_q;
      s4_side_q.in_range <= s3_hit_q;
    end
    if (out_en && div_out_valid) begin
      temp_q  <= temp_d;
      range_q <= div_side.in_range;
    end
  end

  pwl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_v_q),
    .in_ready_o  (div_in_ready),
    .num_i       (s4_num_q),
    .den_i       (s4_span_q),
    .side_i      (s4_side_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (out_en),
    .quo_o       (div_quo),
    .rem_o       (div_rem),
    .side_o      (div_side)
  );

  assign temperature_tenths_o = temp_q;
  assign in_range_o           = range_q;

endmodule

>>> rtl/pwl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_checker
// Port-level checks for the temperature lookup, bound to the top level.
// ----------------------------------------------------------------------------
module pwl_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic [pwl_pkg::CODE_W-1:0]         adc_code_i,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic signed [pwl_pkg::TEMP_W-1:0]  temperature_tenths_o,
  input  logic                               in_range_o
);

  // stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temperature_tenths_o)
                                    && $stable(in_range_o))
    else $error("output beat changed while stalled");

  // valid drops only after the beat was taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output beat withdrawn");

  // out-of-range beats carry zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> temperature_tenths_o == '0)
    else $error("out-of-range beat not zero");

  // in-range beats stay within the table's temperatures
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> temperature_tenths_o >= -12'sd400
                                  && temperature_tenths_o <= 12'sd1100)
    else $error("temperature outside table");

endmodule

bind piecewise_linear_temperature_lookup pwl_checker u_pwl_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .adc_code_i           (adc_code_i),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .temperature_tenths_o (temperature_tenths_o),
  .in_range_o           (in_range_o)
);

>>> tb/sv/piecewise_linear_temperature_lookup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_temperature_lookup_test
// Streams converter codes into the lookup and checks every temperature beat
// against an in-bench interpolation over its own copy of the calibration
// table. Runs in four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module piecewise_linear_temperature_lookup_test;

  localparam int TABLE_POINTS = 30;
  localparam int CAL_COUNT    = 30;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;    // extra cycles after the last expected beat
  localparam int RANDOM_ITEMS = 225;   // per phase

  // Calibration table: temperature in tenths, scaled code, falling code order
  localparam int CAL_TEMP [CAL_COUNT] = '{
    -400, -350, -300, -250, -200, -150, -100, -50, 0, 50,
    100, 150, 200, 250, 300, 350, 400, 450, 500, 550,
    600, 650, 700, 750, 800, 850, 900, 950, 1000, 1100
  };
  localparam int CAL_CODE [CAL_COUNT] = '{
    12410, 12380, 12340, 12280, 12210, 12110, 11990, 11850, 11660, 11450,
    11180, 10880, 10530, 10130, 9690, 9200, 8680, 8140, 7580, 7010,
    6440, 5890, 5350, 4840, 4370, 3930, 3520, 3150, 2810, 2480
  };

  typedef struct packed {
    logic signed [pwl_pkg::TEMP_W-1:0] temp;
    logic                              in_range;
  } reading_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic [pwl_pkg::CODE_W-1:0]         adc_code_i  = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [pwl_pkg::TEMP_W-1:0]  temperature_tenths_o;
  logic                               in_range_o;

  logic [pwl_pkg::CODE_W-1:0] pending_codes [$];
  reading_t                   expected_readings [$];
  int                         error_count    = 0;
  int                         idle_cycles    = 0;
  int                         send_idle_pct  = 0;
  int                         recv_stall_pct = 0;
  bit                         in_taken       = 1'b0;

  piecewise_linear_temperature_lookup #(
    .TABLE_POINTS(TABLE_POINTS)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .adc_code_i          (adc_code_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_tenths_o(temperature_tenths_o),
    .in_range_o          (in_range_o)
  );

  always #10 clk_i = ~clk_i;

  // Interpolate between the first bracketing pair, truncating toward zero
  function automatic reading_t predict_reading(input logic [pwl_pkg::CODE_W-1:0] code);
    reading_t r;
    longint   scaled;
    longint   span;
    longint   num;
    longint   t;
    int       points;
    bit       found;
    r      = '0;
    found  = 1'b0;
    scaled = longint'(code) * 10;
    points = (TABLE_POINTS > CAL_COUNT) ? CAL_COUNT : TABLE_POINTS;
    for (int i = 0; i + 1 < points; i++) begin
      if (!found && scaled <= CAL_CODE[i] && scaled >= CAL_CODE[i+1]) begin
        found = 1'b1;
        span  = longint'(CAL_CODE[i]) - longint'(CAL_CODE[i+1]);
        if (span == 0) begin
          t = CAL_TEMP[i];
        end else begin
          num = longint'(CAL_TEMP[i]) * span +
                (longint'(CAL_TEMP[i]) - longint'(CAL_TEMP[i+1])) *
                (scaled - longint'(CAL_CODE[i]));
          t   = num / span;
        end
        r.temp     = t[pwl_pkg::TEMP_W-1:0];
        r.in_range = 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly in-table codes, some breakpoints, edges and the full code range
  task automatic queue_random_codes(input int n);
    int  pick;
    int  edge_lo;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        pending_codes.push_back(pwl_pkg::CODE_W'($urandom_range(1241, 248)));
      end else if (pick < 80) begin
        pending_codes.push_back(
          pwl_pkg::CODE_W'(CAL_CODE[$urandom_range(CAL_COUNT-1)] / 10));
      end else if (pick < 90) begin
        edge_lo = ($urandom_range(1) != 0) ? 1236 : 243;
        pending_codes.push_back(pwl_pkg::CODE_W'($urandom_range(edge_lo + 10, edge_lo)));
      end else begin
        pending_codes.push_back(pwl_pkg::CODE_W'($urandom_range(4095)));
      end
    end
  endtask

  // Driver: new beat or hold at the falling edge, random gaps and stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
      in_taken = 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          adc_code_i <= pending_codes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
        in_taken = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check output beats, predict accepted input beats, watchdog
  always @(posedge clk_i) begin
    reading_t exp_r;
    bit       any_beat;
    if (rst_ni) begin
      any_beat = 1'b0;
      if (out_valid_o && out_ready_i) begin
        any_beat = 1'b1;
        if (expected_readings.size() == 0) begin
          $error("output beat with nothing expected: temperature_tenths %0d in_range %0b",
                 temperature_tenths_o, in_range_o);
          error_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (temperature_tenths_o !== exp_r.temp) begin
            $error("temperature_tenths: expected %0d, actual %0d",
                   exp_r.temp, temperature_tenths_o);
            error_count++;
          end
          if (in_range_o !== exp_r.in_range) begin
            $error("in_range: expected %0b, actual %0b", exp_r.in_range, in_range_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        any_beat = 1'b1;
        expected_readings.push_back(predict_reading(adc_code_i));
        in_taken = 1'b1;
      end
      idle_cycles = any_beat ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("piecewise_linear_temperature_lookup test failed");
        $finish;
      end
    end
  end

  // Stimulus phases, drain and verdict
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      while (pending_codes.size() != 0) @(posedge clk_i);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 0) begin
        // code extremes, table ends and just outside them, breakpoints
        pending_codes.push_back(12'd0);
        pending_codes.push_back(12'd4095);
        pending_codes.push_back(12'd1241);
        pending_codes.push_back(12'd1242);
        pending_codes.push_back(12'd248);
        pending_codes.push_back(12'd247);
        pending_codes.push_back(12'd1238);
        pending_codes.push_back(12'd1166);
        pending_codes.push_back(12'd281);
        pending_codes.push_back(12'd1240);
        pending_codes.push_back(12'd249);
        pending_codes.push_back(12'd2048);
        pending_codes.push_back(12'h555);
        pending_codes.push_back(12'hAAA);
        pending_codes.push_back(12'd700);
        pending_codes.push_back(12'd1000);
        pending_codes.push_back(12'd500);
        pending_codes.push_back(12'd1200);
        pending_codes.push_back(12'd300);
        pending_codes.push_back(12'd280);
      end
      queue_random_codes(RANDOM_ITEMS);
    end
    while (pending_codes.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("piecewise_linear_temperature_lookup test passed");
    end else begin
      $display("piecewise_linear_temperature_lookup test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pwl_pkg.sv
rtl/pwl_div.sv
rtl/piecewise_linear_temperature_lookup.sv
rtl/pwl_checker.sv
tb/sv/piecewise_linear_temperature_lookup_test.sv
